FILE: rtl/core/erg_pkg.sv
package erg_pkg;

    // Width of every count field in a request and in the Euclid tables.
    localparam int FIELD_W = 7;

    typedef logic [FIELD_W-1:0] t_field;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;       // take a new request (also flags a rejected one)
        logic div_step;   // one restoring division step
        logic store;      // write quotient and remainder, go one level up
        logic walk_init;  // close the Euclid chain and seed the walk stack
        logic walk_step;  // one step of the tree walk
        logic flush;      // hand the held bit to the output as the last one
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic req_bad;    // request on the input port must be rejected
        logic div_last;   // the current division step is the final one
        logic build_brk;  // the Euclid chain ends with this level
        logic walk_end;   // stack empty or emission cap reached
        logic pend_v;     // a bit is held and not yet delivered
        logic out_free;   // output register can take a result this cycle
    } t_sts;

endpackage

FILE: rtl/core/erg_if.sv
interface erg_req_if;
    import erg_pkg::*;

    logic   valid;
    logic   ready;
    t_field slot_cnt;
    t_field pulse_cnt;

    modport source (output valid, output slot_cnt, output pulse_cnt, input ready);
    modport sink   (input valid, input slot_cnt, input pulse_cnt, output ready);
endinterface

interface erg_res_if;
    logic valid;
    logic ready;
    logic bit_res;
    logic last;
    logic error;

    modport source (output valid, output bit_res, output last, output error, input ready);
    modport sink   (input valid, input bit_res, input last, input error, output ready);
endinterface

FILE: rtl/core/euclidean_rhythm_generator_core.sv
// Channel  | Dir | Payload                      | Per request
// ---------+-----+------------------------------+---------------------------------
// i_req    | in  | slot_cnt, pulse_cnt          | one request
// o_res    | out | bit_res, last, error         | one result per slot, or one error
//
// A request is taken in the idle state. Each Euclid level then runs one divider step
// per dividend bit on the shared restoring divider and one table write. The walk is
// then seeded and advances one step at a time (each pattern bit, push and pop) unless
// a stalled output holds it; the walk end is seen and the final bit is handed over.
// Reset is synchronous and active low; it clears the controller and the stack, level, divider and emission counters.
// A stalled output holds the walk only when a finished bit has nowhere to go.
module euclidean_rhythm_generator_core #(
    parameter int MAX_SLOTS  = 64,
    parameter int MAX_LEVELS = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    erg_req_if.sink   i_req,
    erg_res_if.source o_res
);
    import erg_pkg::*;

    // Commands and status between the sequencer and the datapath.
    t_cmd cmd;
    t_sts sts;

    // The controller accepts a request only when idle. It runs the Euclid chain
    // level by level on the shared divider, then steps through the recursion that
    // builds the pattern until the stack empties or the slot cap is reached.
    erg_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .i_sts       (sts),
        .o_req_ready (i_req.ready),
        .o_cmd       (cmd)
    );

    // The datapath holds the quotient and remainder tables, the walk stack with
    // its per-level child counters, and a one-bit holding stage. Each new bit
    // pushes the previously held one into the output register, so the final bit
    // can be marked as last once the walk is known to be over. A rejected
    // request places a single error result in the same holding stage.
    erg_dp #(
        .MAX_SLOTS  (MAX_SLOTS),
        .MAX_LEVELS (MAX_LEVELS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_slot_cnt   (i_req.slot_cnt),
        .i_pulse_cnt  (i_req.pulse_cnt),
        .i_out_ready  (o_res.ready),
        .o_sts        (sts),
        .o_out_valid  (o_res.valid),
        .o_bit_res    (o_res.bit_res),
        .o_last       (o_res.last),
        .o_error      (o_res.error)
    );

endmodule

FILE: rtl/core/erg_ctrl.sv
module erg_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_req_valid,
    input  erg_pkg::t_sts i_sts,
    output logic          o_req_ready,
    output erg_pkg::t_cmd o_cmd
);
    import erg_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_STORE,
        S_WINIT,
        S_WALK,
        S_FLUSH
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_req_ready = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_req_ready = 1'b1;
                if (i_req_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = i_sts.req_bad ? S_FLUSH : S_DIV;
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_last) begin
                    n_state = S_STORE;
                end
            end
            S_STORE: begin
                o_cmd.store = 1'b1;
                n_state     = i_sts.build_brk ? S_WINIT : S_DIV;
            end
            S_WINIT: begin
                o_cmd.walk_init = 1'b1;
                n_state         = S_WALK;
            end
            S_WALK: begin
                if (i_sts.walk_end) begin
                    n_state = S_FLUSH;
                end else begin
                    o_cmd.walk_step = 1'b1;
                end
            end
            S_FLUSH: begin
                o_cmd.flush = 1'b1;
                if (!i_sts.pend_v || i_sts.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

FILE: rtl/core/erg_dp.sv
module erg_dp #(
    parameter int MAX_SLOTS  = 64,
    parameter int MAX_LEVELS = 16
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  erg_pkg::t_cmd   i_cmd,
    input  erg_pkg::t_field i_slot_cnt,
    input  erg_pkg::t_field i_pulse_cnt,
    input  logic            i_out_ready,
    output erg_pkg::t_sts   o_sts,
    output logic            o_out_valid,
    output logic            o_bit_res,
    output logic            o_last,
    output logic            o_error
);
    import erg_pkg::*;

    localparam int LW  = $clog2(MAX_LEVELS);
    localparam int SPW = $clog2(MAX_LEVELS + 1);
    localparam int KW  = $clog2(MAX_SLOTS + 1);
    localparam int DW  = $clog2(FIELD_W);

    // Euclid tables and walk state
    t_field         r_cnt [MAX_LEVELS];
    t_field         r_rem [MAX_LEVELS];
    t_field         r_lc  [MAX_LEVELS];
    logic [LW-1:0]  r_stk [MAX_LEVELS];
    logic [SPW-1:0] r_sp;
    logic [KW-1:0]  r_k;
    logic [LW-1:0]  r_lv;

    // Divider
    t_field         r_rdiv;
    t_field         r_rr;
    t_field         r_dq;
    t_field         r_acc;
    logic [DW-1:0]  r_dcnt;

    // Held bit and output register
    logic           r_pend_v;
    logic           r_pend_bit;
    logic           r_pend_err;
    logic           r_out_v;
    logic           r_out_bit;
    logic           r_out_last;
    logic           r_out_err;

    logic             req_bad;
    t_field           diff;
    logic [FIELD_W:0] div_t;
    logic [FIELD_W:0] div_sub;
    logic             div_ge;
    logic [LW-1:0]    lv_p1;
    logic             out_free;

    logic [SPW-1:0]   sp_m1;
    logic [LW-1:0]    wlv;
    t_field           wc;
    t_field           wcnt;
    t_field           wrem;
    logic             take_a;
    logic             take_b;
    logic             do_emit;
    logic             do_push;
    logic             emit_bit;
    logic [LW-1:0]    child;
    logic             stall;
    logic             step_go;
    logic             out_load;
    logic             out_last;

    assign req_bad = (i_pulse_cnt == '0) || (i_pulse_cnt > (i_slot_cnt >> 1))
                     || (i_slot_cnt > FIELD_W'(MAX_SLOTS));
    assign diff    = i_slot_cnt - i_pulse_cnt;

    // One restoring division step: shift in the next dividend bit, try to subtract.
    assign div_t   = {r_acc, r_dq[FIELD_W-1]};
    assign div_ge  = div_t >= {1'b0, r_rr};
    assign div_sub = div_t - {1'b0, r_rr};
    assign lv_p1   = r_lv + 1'b1;

    assign out_free = !r_out_v || i_out_ready;

    // Node on top of the walk stack and its table entries.
    assign sp_m1  = r_sp - 1'b1;
    assign wlv    = r_stk[sp_m1[LW-1:0]];
    assign wc     = r_lc[wlv];
    assign wcnt   = r_cnt[wlv];
    assign wrem   = r_rem[wlv];
    assign take_a = wc < wcnt;
    assign take_b = !take_a && (wc == wcnt) && (wrem != '0);

    // Descending below level zero yields a rest, two below yields a pulse.
    assign do_emit  = (take_a && (wlv == '0))
                      || (take_b && ((wlv == '0) || (wlv == LW'(1))));
    assign do_push  = (take_a && (wlv != '0)) || (take_b && (wlv > LW'(1)));
    assign emit_bit = take_b && (wlv == '0);
    assign child    = take_a ? (wlv - LW'(1)) : (wlv - LW'(2));
    assign stall    = do_emit && r_pend_v && !out_free;
    assign step_go  = i_cmd.walk_step && !stall;

    assign out_load = (step_go && do_emit && r_pend_v)
                      || (i_cmd.flush && r_pend_v && out_free);
    assign out_last = i_cmd.flush;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sp     <= '0;
            r_k      <= '0;
            r_lv     <= '0;
            r_rdiv   <= '0;
            r_dcnt   <= '0;
            r_pend_v <= 1'b0;
            r_out_v  <= 1'b0;
        end else begin
            if (out_load) begin
                r_out_v <= 1'b1;
            end else if (i_out_ready) begin
                r_out_v <= 1'b0;
            end

            if (i_cmd.load) begin
                r_k      <= '0;
                r_sp     <= '0;
                r_lv     <= '0;
                r_rdiv   <= diff;
                r_dq     <= diff;
                r_rr     <= i_pulse_cnt;
                r_acc    <= '0;
                r_dcnt   <= '0;
                r_rem[0] <= i_pulse_cnt;
                if (req_bad) begin
                    r_pend_v   <= 1'b1;
                    r_pend_bit <= 1'b0;
                    r_pend_err <= 1'b1;
                end
            end

            if (i_cmd.div_step) begin
                r_acc  <= div_ge ? div_sub[FIELD_W-1:0] : div_t[FIELD_W-1:0];
                r_dq   <= {r_dq[FIELD_W-2:0], div_ge};
                r_dcnt <= r_dcnt + 1'b1;
            end

            if (i_cmd.store) begin
                r_cnt[r_lv]  <= r_dq;
                r_rem[lv_p1] <= r_acc;
                r_rdiv       <= r_rr;
                r_dq         <= r_rr;
                r_rr         <= r_acc;
                r_acc        <= '0;
                r_dcnt       <= '0;
                r_lv         <= lv_p1;
            end

            if (i_cmd.walk_init) begin
                r_cnt[r_lv] <= r_rdiv;
                r_stk[0]    <= r_lv;
                r_lc[r_lv]  <= '0;
                r_sp        <= SPW'(1);
                r_k         <= '0;
            end

            if (step_go) begin
                if (take_a || take_b) begin
                    r_lc[wlv] <= wc + 1'b1;
                    if (do_emit) begin
                        r_pend_v   <= 1'b1;
                        r_pend_bit <= emit_bit;
                        r_pend_err <= 1'b0;
                        r_k        <= r_k + 1'b1;
                    end else if (do_push && (r_sp < SPW'(MAX_LEVELS))) begin
                        r_stk[r_sp[LW-1:0]] <= child;
                        r_lc[child]         <= '0;
                        r_sp                <= r_sp + 1'b1;
                    end
                end else begin
                    r_sp <= sp_m1;
                end
            end

            if (i_cmd.flush && r_pend_v && out_free) begin
                r_pend_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_bit  <= r_pend_bit;
            r_out_last <= out_last;
            r_out_err  <= r_pend_err;
        end
    end

    always_comb begin
        o_sts           = '0;
        o_sts.req_bad   = req_bad;
        o_sts.div_last  = (r_dcnt == DW'(FIELD_W - 1));
        o_sts.build_brk = (r_acc <= FIELD_W'(1)) || (r_lv >= LW'(MAX_LEVELS - 2));
        o_sts.walk_end  = (r_sp == '0) || (r_k == KW'(MAX_SLOTS));
        o_sts.pend_v    = r_pend_v;
        o_sts.out_free  = out_free;
    end

    assign o_out_valid = r_out_v;
    assign o_bit_res   = r_out_bit;
    assign o_last      = r_out_last;
    assign o_error     = r_out_err;

endmodule

FILE: tb/sv/euclidean_rhythm_generator_core_tb.sv
module euclidean_rhythm_generator_core_tb;
    import erg_pkg::*;

    // These match the defaults of the block under test.
    localparam int MAX_SLOTS   = 64;
    localparam int MAX_LEVELS  = 16;
    // Length of the long output hold-off that fills the block up.
    localparam int HOLD_CYCLES = 300;
    // Cycles with no transfer on either channel before the run is declared hung.
    localparam int STALL_LIMIT = 3000;
    // Quiet cycles after the last expected result, to catch stray extra results.
    localparam int TAIL_CYCLES = 300;
    localparam int N_DIRECTED  = 22;

    // One pattern step as it leaves the block.
    typedef struct packed {
        logic bit_res;
        logic last;
        logic error;
    } step_result_t;

    // The scoreboard predicts the whole rhythm of each accepted request and then
    // matches the results of the block, in order, against that prediction.
    class rhythm_scoreboard;
        step_result_t expected_steps[$];
        int           requests;
        int           rejected;
        int           checked;
        int           mismatches;

        function new();
            requests   = 0;
            rejected   = 0;
            checked    = 0;
            mismatches = 0;
        endfunction

        function int pending();
            return expected_steps.size();
        endfunction

        // Runs the Euclid chain and the tree walk for one request and queues the
        // resulting steps.
        function void note_request(t_field slots, t_field pulses);
            t_field       quot   [MAX_LEVELS];
            t_field       rem    [MAX_LEVELS];
            t_field       seen   [MAX_LEVELS];
            int           stack  [MAX_LEVELS];
            step_result_t steps[$];
            step_result_t step;
            t_field       divisor;
            int           top;
            int           sp;
            int           lv;
            int           child;

            requests++;
            if (pulses == 0 || pulses > slots / 2 || slots > MAX_SLOTS) begin
                rejected++;
                step = '{bit_res: 1'b0, last: 1'b1, error: 1'b1};
                expected_steps.push_back(step);
                return;
            end

            // Euclid chain: the divisor moves to the previous remainder at each level.
            divisor = slots - pulses;
            rem[0]  = pulses;
            top     = 0;
            forever begin
                quot[top]    = divisor / rem[top];
                rem[top + 1] = divisor % rem[top];
                divisor      = rem[top];
                top++;
                if (rem[top] <= 1 || top >= MAX_LEVELS - 1) break;
            end
            quot[top] = divisor;

            // Walk the build recursion: a level first visits quot[lv] copies of the
            // level below, then one copy of the level two below if its remainder is
            // nonzero. Level -1 is a rest and level -2 is a pulse.
            stack[0]  = top;
            seen[top] = '0;
            sp        = 1;
            while (sp > 0 && steps.size() < MAX_SLOTS) begin
                lv = stack[sp - 1];
                if (seen[lv] < quot[lv]) begin
                    seen[lv]++;
                    child = lv - 1;
                end else if (seen[lv] == quot[lv] && rem[lv] != 0) begin
                    seen[lv]++;
                    child = lv - 2;
                end else begin
                    sp--;
                    continue;
                end
                if (child < 0) begin
                    step = '{bit_res: (child == -2), last: 1'b0, error: 1'b0};
                    steps.push_back(step);
                end else if (sp < MAX_LEVELS) begin
                    stack[sp]   = child;
                    seen[child] = '0;
                    sp++;
                end
            end

            foreach (steps[i]) begin
                step      = steps[i];
                step.last = (i == steps.size() - 1);
                expected_steps.push_back(step);
            end
        endfunction

        function void compare_field(string name, logic want, logic got);
            if (got !== want) begin
                mismatches++;
                $display("%0t: %s mismatch on result %0d, expected %0b, actual %0b",
                         $time, name, checked, want, got);
            end
        endfunction

        function void check_result(step_result_t got);
            step_result_t want;
            if (expected_steps.size() == 0) begin
                mismatches++;
                $display("%0t: result with nothing expected, expected none, actual %b",
                         $time, got);
                return;
            end
            want = expected_steps.pop_front();
            compare_field("bit_res", want.bit_res, got.bit_res);
            compare_field("last", want.last, got.last);
            compare_field("error", want.error, got.error);
            checked++;
        endfunction
    endclass

    logic i_clk   = 1'b0;
    logic i_rst_n;

    erg_req_if req_if ();
    erg_res_if res_if ();

    euclidean_rhythm_generator_core #(
        .MAX_SLOTS (MAX_SLOTS),
        .MAX_LEVELS(MAX_LEVELS)
    ) uut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req_if),
        .o_res  (res_if)
    );

    rhythm_scoreboard sb;

    // Random idling on both channels is enabled while this is set.
    bit idle_on   = 1'b1;
    // The main process bumps hold_asks to ask the receiver for one long hold-off;
    // the receiver bumps hold_done when it has served it.
    int hold_asks = 0;
    int hold_done = 0;

    // Directed requests: the smallest pattern, the largest ones (which also hit
    // the emission cap of 64 bits), several deeper Euclid chains, and the
    // rejected forms: zero pulses, too many pulses, too many slots, and the
    // all-ones values of both fields.
    t_field directed_slots  [N_DIRECTED] = '{
        7'd2, 7'd3, 7'd4, 7'd5, 7'd7, 7'd8, 7'd12, 7'd13, 7'd16, 7'd21, 7'd64,
        7'd64, 7'd64, 7'd55, 7'd2, 7'd0, 7'd1, 7'd5, 7'd65, 7'd127, 7'd64, 7'd127
    };
    t_field directed_pulses [N_DIRECTED] = '{
        7'd1, 7'd1, 7'd2, 7'd2, 7'd3, 7'd3, 7'd5, 7'd5, 7'd7, 7'd8, 7'd1,
        7'd32, 7'd31, 7'd21, 7'd0, 7'd0, 7'd1, 7'd3, 7'd1, 7'd127, 7'd33, 7'd0
    };

    always #1 i_clk = ~i_clk;

    // Both channels are observed at the clock edge, where the values seen are
    // the ones that held just before it, so a transfer is exactly valid && ready.
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && req_if.valid && req_if.ready)
            sb.note_request(req_if.slot_cnt, req_if.pulse_cnt);
        if (i_rst_n === 1'b1 && res_if.valid && res_if.ready)
            sb.check_result(step_result_t'{res_if.bit_res, res_if.last, res_if.error});
    end

    // Result side: random stall bursts while idling is on, and
    // one long hold-off on request from the main process.
    initial begin
        int gap;
        gap = 0;
        res_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_asks != hold_done) begin
                res_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_done++;
            end else if (gap > 0) begin
                res_if.ready <= 1'b0;
                gap--;
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
                res_if.ready <= 1'b0;
                gap = $urandom_range(0, 10);
            end else begin
                res_if.ready <= 1'b1;
            end
        end
    end

    // Offers one request and returns at the edge where it is taken. Valid is
    // left high, so back-to-back requests need no second assignment.
    task automatic send_request(input t_field slots, input t_field pulses);
        if (idle_on && $urandom_range(0, 2) == 0) begin
            req_if.valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge i_clk);
        end
        req_if.valid     <= 1'b1;
        req_if.slot_cnt  <= slots;
        req_if.pulse_cnt <= pulses;
        @(posedge i_clk);
        while (!req_if.ready) @(posedge i_clk);
    endtask

    // Mostly well-formed requests, most of them small; the rest is noise over
    // the full 7-bit range of both fields, much of which the block must reject.
    task automatic random_request();
        t_field slots;
        t_field pulses;
        if ($urandom_range(0, 99) < 15) begin
            slots  = t_field'($urandom_range(0, 127));
            pulses = t_field'($urandom_range(0, 127));
        end else begin
            slots  = ($urandom_range(0, 4) == 0) ? t_field'($urandom_range(33, 64))
                                                 : t_field'($urandom_range(2, 32));
            pulses = t_field'($urandom_range(1, slots / 2));
        end
        send_request(slots, pulses);
    endtask

    // The first edge lets the sampling process record a request taken just now.
    task automatic wait_drained();
        @(posedge i_clk);
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    initial begin
        sb = new();
        i_rst_n          <= 1'b0;
        req_if.valid     <= 1'b0;
        req_if.slot_cnt  <= '0;
        req_if.pulse_cnt <= '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int i = 0; i < N_DIRECTED; i++)
            send_request(directed_slots[i], directed_pulses[i]);

        // First random stretch with idling on both sides. Partway through, the
        // receiver holds off for a long time while requests keep coming, so
        // the block backs up and stops taking requests.
        for (int i = 0; i < 70; i++) begin
            if (i == 30) hold_asks++;
            random_request();
        end

        // The sender goes quiet until every outstanding result has come back.
        req_if.valid <= 1'b0;
        wait_drained();

        for (int i = 0; i < 45; i++)
            random_request();

        // Last stretch at full rate on both sides.
        idle_on = 1'b0;
        for (int i = 0; i < 33; i++)
            random_request();
        req_if.valid <= 1'b0;

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Ran %0d requests (%0d rejected) and checked %0d results,", sb.requests,
                 sb.rejected, sb.checked);
        $display("with bursty idling, a long result hold-off and a full drain pause.");
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // Watchdog: any cycle that moves a request or a result restarts the count.
    initial begin
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if (i_rst_n !== 1'b1 || (req_if.valid && req_if.ready)
                || (res_if.valid && res_if.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("%0t: nothing moved for %0d cycles", $time, STALL_LIMIT);
        $display("Simulation FAILED");
        $finish;
    end

endmodule

FILE: sim.f
rtl/core/erg_pkg.sv
rtl/core/erg_if.sv
rtl/core/erg_ctrl.sv
rtl/core/erg_dp.sv
rtl/core/euclidean_rhythm_generator_core.sv
tb/sv/euclidean_rhythm_generator_core_tb.sv
